// ===== sv/rth_pkg.sv =====
package rth_pkg;

  localparam int CH_W  = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 13;

  // degrees per hue sector, before the fractional shift
  localparam int SECTOR_DEG = 60;

  // quotient bits resolved by one divider stage
  localparam int DIV_BITS_PER_STAGE = 4;

  localparam int LANES    = 2;
  localparam int LANE_SAT = 0;
  localparam int LANE_HUE = 1;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } in_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  brightness_value;
  } out_t;

  // per-pixel info carried alongside the divider lanes
  typedef struct packed {
    sector_t         sector;
    logic            neg;
    logic            black;
    logic            gray;
    logic [CH_W-1:0] value;
  } side_t;

endpackage

// ===== sv/rth_front.sv =====
module rth_front import rth_pkg::*; #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 12,
  parameter int QW = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  in_t                               in_data,
  output logic                              dn_valid,
  input  logic                              dn_stall,
  output logic [LANES-1:0][CH_W-1:0]        dn_rem,
  output logic [LANES-1:0][QW-1:0]          dn_nq,
  output logic [LANES-1:0][CH_W-1:0]        dn_den,
  output side_t                             dn_side
);

  localparam int NW = CH_W + QW;

  logic                       valid_r;
  logic                       advance;
  logic [LANES-1:0][CH_W-1:0] rem_r, rem_nxt;
  logic [LANES-1:0][QW-1:0]   nq_r, nq_nxt;
  logic [LANES-1:0][CH_W-1:0] den_r, den_nxt;
  side_t                      side_r, side_nxt;

  logic [CH_W-1:0]   mx, mn, delta, absdiff;
  logic signed [8:0] diff;
  logic [8:0]        mag;
  logic [13:0]       hmul;
  logic [NW-1:0]     sat_num, hue_num;
  sector_t           sector;

  assign advance  = !valid_r || !dn_stall;
  assign in_stall = !advance;

  always_comb begin
    if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
      sector = SECT_RED;
      mx     = in_data.red;
      diff   = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
    end else if (in_data.green >= in_data.blue) begin
      sector = SECT_GREEN;
      mx     = in_data.green;
      diff   = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
    end else begin
      sector = SECT_BLUE;
      mx     = in_data.blue;
      diff   = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
    end

    mn = in_data.red;
    if (in_data.green < mn) mn = in_data.green;
    if (in_data.blue < mn) mn = in_data.blue;
    delta = mx - mn;

    mag     = diff[8] ? 9'(-diff) : 9'(diff);
    absdiff = mag[CH_W-1:0];
    hmul    = 14'(absdiff) * 14'(SECTOR_DEG);

    sat_num = NW'(delta) << SAT_FRAC_BITS;
    hue_num = NW'(hmul) << HUE_FRAC_BITS;

    // upper numerator bits seed the remainder; they stay below the divisor
    rem_nxt[LANE_SAT] = sat_num[NW-1:QW];
    nq_nxt[LANE_SAT]  = sat_num[QW-1:0];
    den_nxt[LANE_SAT] = mx;
    rem_nxt[LANE_HUE] = hue_num[NW-1:QW];
    nq_nxt[LANE_HUE]  = hue_num[QW-1:0];
    den_nxt[LANE_HUE] = delta;

    side_nxt.sector = sector;
    side_nxt.neg    = diff[8];
    side_nxt.black  = (mx == '0);
    side_nxt.gray   = (delta == '0);
    side_nxt.value  = mx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_nq    = nq_r;
  assign dn_den   = den_r;
  assign dn_side  = side_r;

endmodule

// ===== sv/rth_div_stage.sv =====
module rth_div_stage import rth_pkg::*; #(
  parameter int QW = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  logic [LANES-1:0][CH_W-1:0] up_rem,
  input  logic [LANES-1:0][QW-1:0]   up_nq,
  input  logic [LANES-1:0][CH_W-1:0] up_den,
  input  side_t                      up_side,
  output logic                       dn_valid,
  input  logic                       dn_stall,
  output logic [LANES-1:0][CH_W-1:0] dn_rem,
  output logic [LANES-1:0][QW-1:0]   dn_nq,
  output logic [LANES-1:0][CH_W-1:0] dn_den,
  output side_t                      dn_side
);

  logic                       valid_r;
  logic                       advance;
  logic [LANES-1:0][CH_W-1:0] rem_r, rem_nxt;
  logic [LANES-1:0][QW-1:0]   nq_r, nq_nxt;
  logic [LANES-1:0][CH_W-1:0] den_r;
  side_t                      side_r;

  assign advance  = !valid_r || !dn_stall;
  assign up_stall = !advance;

  // restoring division: shift a numerator bit into the remainder,
  // subtract when it fits, shift the quotient bit in at the bottom
  always_comb begin
    logic [CH_W-1:0] rem;
    logic [QW-1:0]   nq;
    logic [CH_W:0]   trial;
    for (int l = 0; l < LANES; l++) begin
      rem = up_rem[l];
      nq  = up_nq[l];
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
        trial = {rem, nq[QW-1]};
        nq    = {nq[QW-2:0], 1'b0};
        if (trial >= {1'b0, up_den[l]}) begin
          rem   = CH_W'(trial - {1'b0, up_den[l]});
          nq[0] = 1'b1;
        end else begin
          rem = trial[CH_W-1:0];
        end
      end
      rem_nxt[l] = rem;
      nq_nxt[l]  = nq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
      den_r  <= up_den;
      side_r <= up_side;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_nq    = nq_r;
  assign dn_den   = den_r;
  assign dn_side  = side_r;

endmodule

// ===== sv/rth_back.sv =====
module rth_back import rth_pkg::*; #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int QW = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_stall,
  input  logic [LANES-1:0][QW-1:0] up_quot,
  input  side_t                    up_side,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_t                     out_data
);

  localparam int UNIT = SECTOR_DEG << HUE_FRAC_BITS;
  localparam int HW   = QW + 4;

  logic                valid_r;
  logic                advance;
  out_t                data_r, data_nxt;
  logic signed [HW-1:0] q_s, off, h;

  assign advance  = !valid_r || !out_stall;
  assign up_stall = !advance;

  always_comb begin
    q_s = $signed({4'b0, up_quot[LANE_HUE]});
    case (up_side.sector)
      SECT_GREEN: off = HW'(2 * UNIT);
      SECT_BLUE:  off = HW'(4 * UNIT);
      default:    off = '0;
    endcase
    h = up_side.neg ? off - q_s : off + q_s;
    // wrap negative angles into the upper turn
    if (h < 0) h = h + HW'(6 * UNIT);

    data_nxt.hue              = up_side.gray ? '0 : HUE_W'($unsigned(h));
    data_nxt.saturation       = up_side.black ? '0 : SAT_W'(up_quot[LANE_SAT]);
    data_nxt.brightness_value = up_side.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== sv/rgb_to_hsv.sv =====
// Pipeline: front stage, one divider stage per 4 quotient bits, output stage;
// NSTG divider stages, where NSTG = ceil(max(SAT_FRAC_BITS + 1, HUE_FRAC_BITS + 6) / 4).
// Throughput: one pixel per clock while out_stall is low; each divider stage resolves 4 quotient bits.
// Reset (synchronous, active low) clears the stage valid bits only.
module rgb_to_hsv import rth_pkg::*; #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_FRAC_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int QW_MIN = (SAT_FRAC_BITS + 1 > HUE_FRAC_BITS + 6) ?
                          SAT_FRAC_BITS + 1 : HUE_FRAC_BITS + 6;
  localparam int NSTG   = (QW_MIN + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
  localparam int QW     = NSTG * DIV_BITS_PER_STAGE;

  logic                       vld_a   [0:NSTG];
  logic                       stall_a [0:NSTG];
  logic [LANES-1:0][CH_W-1:0] rem_a   [0:NSTG];
  logic [LANES-1:0][QW-1:0]   nq_a    [0:NSTG];
  logic [LANES-1:0][CH_W-1:0] den_a   [0:NSTG];
  side_t                      side_a  [0:NSTG];

  rth_front #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_FRAC_BITS (SAT_FRAC_BITS),
    .QW            (QW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .dn_valid (vld_a[0]),
    .dn_stall (stall_a[0]),
    .dn_rem   (rem_a[0]),
    .dn_nq    (nq_a[0]),
    .dn_den   (den_a[0]),
    .dn_side  (side_a[0])
  );

  for (genvar i = 0; i < NSTG; i++) begin : g_div
    rth_div_stage #(
      .QW (QW)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld_a[i]),
      .up_stall (stall_a[i]),
      .up_rem   (rem_a[i]),
      .up_nq    (nq_a[i]),
      .up_den   (den_a[i]),
      .up_side  (side_a[i]),
      .dn_valid (vld_a[i+1]),
      .dn_stall (stall_a[i+1]),
      .dn_rem   (rem_a[i+1]),
      .dn_nq    (nq_a[i+1]),
      .dn_den   (den_a[i+1]),
      .dn_side  (side_a[i+1])
    );
  end

  rth_back #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .QW            (QW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (vld_a[NSTG]),
    .up_stall  (stall_a[NSTG]),
    .up_quot   (nq_a[NSTG]),
    .up_side   (side_a[NSTG]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
